>>> hdl/kwm_pkg.sv
// Shared constants, types and key helpers for the k-way merge selector.
package kwm_pkg;

    localparam int MAX_RUNS      = 16;
    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_W         = 64;
    localparam int LEN_W         = 4;
    localparam int IDX_W         = 4;
    localparam int RUN_W         = $clog2(MAX_RUNS);
    localparam int CNT_W         = $clog2(MAX_RUNS + 1);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_START   = 2'd1,
        OP_REFILL  = 2'd2,
        OP_EXHAUST = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             en;
        logic [RUN_W-1:0] addr;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } head_wr_t;

    typedef struct packed {
        logic             en;
        logic [RUN_W-1:0] addr;
    } head_rd_t;

    // Keep the first n bytes of a left-aligned key.
    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            if (LEN_W'(i) < n)
            begin
                m[KEY_W-1-8*i -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
        return (n > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : n;
    endfunction

endpackage

>>> hdl/kwm_if.sv
// Valid/ready channel interfaces for request and response transfers.
interface kwm_req_if;
    import kwm_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       operation;
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_length;

    modport source (output valid, output operation, output key_bytes,
                    output key_length, input ready);
    modport sink   (input valid, input operation, input key_bytes,
                    input key_length, output ready);
endinterface

interface kwm_rsp_if;
    import kwm_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] run_index;
    logic [KEY_W-1:0] winner_key;
    logic [LEN_W-1:0] winner_length;
    logic             merge_done;

    modport source (output valid, output run_index, output winner_key,
                    output winner_length, output merge_done, input ready);
    modport sink   (input valid, input run_index, input winner_key,
                    input winner_length, input merge_done, output ready);
endinterface

>>> hdl/kwm_head_store.sv
// Head key memory: one write port, one registered read port.
module kwm_head_store (
    input  logic                    clk,
    input  kwm_pkg::head_wr_t       wr,
    input  kwm_pkg::head_rd_t       rd,
    output logic [kwm_pkg::KEY_W-1:0] rd_key,
    output logic [kwm_pkg::LEN_W-1:0] rd_len
);
    import kwm_pkg::*;

    logic [KEY_W-1:0] key_mem [MAX_RUNS];
    logic [LEN_W-1:0] len_mem [MAX_RUNS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr] <= wr.key;
            len_mem[wr.addr] <= wr.len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_key <= key_mem[rd.addr];
            rd_len <= len_mem[rd.addr];
        end
    end

endmodule

>>> hdl/kwm_key_cmp.sv
// Lexicographic key compare: shorter prefix orders first.
module kwm_key_cmp (
    input  logic [kwm_pkg::KEY_W-1:0] a_key,
    input  logic [kwm_pkg::LEN_W-1:0] a_len,
    input  logic [kwm_pkg::KEY_W-1:0] b_key,
    input  logic [kwm_pkg::LEN_W-1:0] b_len,
    output logic                      a_before_b
);
    import kwm_pkg::*;

    logic [LEN_W-1:0] common;
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] ca;
    logic [KEY_W-1:0] cb;

    always_comb
    begin
        common     = (a_len < b_len) ? a_len : b_len;
        m          = byte_mask(common);
        ca         = a_key & m;
        cb         = b_key & m;
        a_before_b = (ca != cb) ? (ca < cb) : (a_len < b_len);
    end

endmodule

>>> hdl/k_way_merge_selector.sv
// Top level of the k-way merge selector: sequencer, run state and output register.
//
//  channel | dir | payload                                          | handshake
//  req     | in  | operation, key_bytes, key_length                 | valid/ready
//  rsp     | out | run_index, winner_key, winner_length, merge_done | valid/ready
//
// Start, and refill or exhaust during a merge, begin a selection: one compare
// unit walks the heads one a cycle through the single read port of the head
// store, then the winner is loaded.
// Reset clears run state only; the head store needs no clearing pass.
// A finished result waits in the output register while an add is taken;
// a new selection holds in its last step until that register is free.
module k_way_merge_selector (
    input  logic          clk,
    input  logic          rst_n,
    kwm_req_if.sink       req,
    kwm_rsp_if.source     rsp
);
    import kwm_pkg::*;

    state_t            state_reg, state_next;
    logic [RUN_W-1:0]  scan_idx_reg;
    logic              rd_vld_reg;
    logic [RUN_W-1:0]  rd_idx_reg;
    logic              found_reg;
    logic [RUN_W-1:0]  best_idx_reg;
    logic [KEY_W-1:0]  best_key_reg;
    logic [LEN_W-1:0]  best_len_reg;
    logic [MAX_RUNS-1:0] active_reg;
    logic [CNT_W-1:0]  run_count_reg;
    logic [RUN_W-1:0]  sel_reg;
    logic              merging_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_done_reg;

    op_t               op;
    logic              accept;
    logic              start_scan;
    logic              room;
    logic [LEN_W-1:0]  len_in;
    logic [KEY_W-1:0]  key_in;
    logic              emit_load;
    logic              cand_before;
    logic              take_cand;
    head_wr_t          wr;
    head_rd_t          rd;
    logic [KEY_W-1:0]  rd_key;
    logic [LEN_W-1:0]  rd_len;

    assign op      = op_t'(req.operation);
    assign accept  = req.valid && req.ready;
    assign room    = run_count_reg < CNT_W'(MAX_RUNS);
    assign len_in  = clamp_len(req.key_length);
    assign key_in  = req.key_bytes & byte_mask(len_in);
    assign req.ready = (state_reg == ST_IDLE);

    assign start_scan = accept && ((op == OP_START) ||
                        (merging_reg && (op == OP_REFILL || op == OP_EXHAUST)));

    always_comb
    begin
        wr.en   = accept && ((op == OP_ADD && room) ||
                  (op == OP_REFILL && merging_reg && active_reg[sel_reg]));
        wr.addr = (op == OP_ADD) ? run_count_reg[RUN_W-1:0] : sel_reg;
        wr.key  = key_in;
        wr.len  = len_in;
        rd.en   = (state_reg == ST_SCAN);
        rd.addr = scan_idx_reg;
    end

    kwm_head_store u_store (
        .clk    (clk),
        .wr     (wr),
        .rd     (rd),
        .rd_key (rd_key),
        .rd_len (rd_len)
    );

    kwm_key_cmp u_cmp (
        .a_key      (rd_key),
        .a_len      (rd_len),
        .b_key      (best_key_reg),
        .b_len      (best_len_reg),
        .a_before_b (cand_before)
    );

    // Strict compare keeps the lower run index on ties.
    assign take_cand = rd_vld_reg && active_reg[rd_idx_reg] &&
                       (!found_reg || cand_before);
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == RUN_W'(MAX_RUNS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Scan pointer and read tag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd.en;
            rd_idx_reg <= scan_idx_reg;
            if (start_scan)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (rd.en)
                begin
                    scan_idx_reg <= scan_idx_reg + RUN_W'(1);
                end
                if (take_cand)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cand)
        begin
            best_idx_reg <= rd_idx_reg;
            best_key_reg <= rd_key;
            best_len_reg <= rd_len;
        end
    end

    // Run bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            run_count_reg <= '0;
            sel_reg       <= '0;
            merging_reg   <= 1'b0;
        end
        else
        begin
            if (accept && op == OP_ADD && room)
            begin
                active_reg[run_count_reg[RUN_W-1:0]] <= 1'b1;
                run_count_reg <= run_count_reg + CNT_W'(1);
            end
            if (accept && op == OP_EXHAUST && merging_reg)
            begin
                active_reg[sel_reg] <= 1'b0;
            end
            if (accept && op == OP_START)
            begin
                merging_reg <= 1'b1;
            end
            if (emit_load && found_reg)
            begin
                sel_reg <= best_idx_reg;
            end
        end
    end

    // Output register: hold until the response transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_done_reg <= !found_reg;
            out_idx_reg  <= found_reg ? IDX_W'(best_idx_reg) : '0;
            out_key_reg  <= found_reg ? best_key_reg : '0;
            out_len_reg  <= found_reg ? best_len_reg : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.run_index     = out_idx_reg;
    assign rsp.winner_key    = out_key_reg;
    assign rsp.winner_length = out_len_reg;
    assign rsp.merge_done    = out_done_reg;

endmodule

>>> hdl/kwm_checker.sv
// Port-level checks for the k-way merge selector, bound to the top level.
module kwm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic [1:0]                req_operation,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [kwm_pkg::IDX_W-1:0] rsp_run_index,
    input logic [kwm_pkg::KEY_W-1:0] rsp_winner_key,
    input logic [kwm_pkg::LEN_W-1:0] rsp_winner_length,
    input logic                      rsp_merge_done
);
    import kwm_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_winner_key)
            && $stable(rsp_run_index) && $stable(rsp_merge_done))
        else $error("response changed while stalled");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_merge_done |-> rsp_run_index == '0
            && rsp_winner_key == '0 && rsp_winner_length == '0)
        else $error("merge_done with nonzero result fields");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_merge_done |-> rsp_winner_length <= LEN_W'(MAX_KEY_BYTES))
        else $error("winner length above maximum");

    a_key_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_merge_done |->
            (rsp_winner_key & ~byte_mask(rsp_winner_length)) == '0)
        else $error("winner key has bytes beyond its length");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_operation == OP_START |=> !req_ready)
        else $error("ready during selection");

endmodule

bind k_way_merge_selector kwm_checker u_kwm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_operation     (req.operation),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_run_index     (rsp.run_index),
    .rsp_winner_key    (rsp.winner_key),
    .rsp_winner_length (rsp.winner_length),
    .rsp_merge_done    (rsp.merge_done)
);
